### hdl/pru_pkg.sv
// Shared types and constants for the pixel replicate upscaler.
package pru_pkg;

	// Default sizing
	localparam int unsigned DEF_MAX_WIDTH = 4096;
	localparam int unsigned DEF_MAX_SCALE = 32;

	// Fixed register and field widths
	localparam int unsigned SRC_WIDTH_W = 13;
	localparam int unsigned SCALE_W     = 6;
	localparam int unsigned COLOR_W     = 8;
	localparam int unsigned PIX_W       = 3 * COLOR_W;
	localparam int unsigned APB_ADDR_W  = 3;
	localparam int unsigned APB_DATA_W  = 32;
	localparam int unsigned PAD_W       = 2;

	// Input operation codes
	typedef enum logic [0:0] {
		OP_PIXEL = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PIXEL  = 2'd0,
		KIND_PAD    = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	// Register index, taken from paddr[2]
	typedef enum logic [0:0] {
		REG_SOURCE_WIDTH = 1'b0,
		REG_SCALE_FACTOR = 1'b1
	} reg_idx_t;

endpackage

### hdl/pixel_replicate_upscaler.sv
// Nearest-neighbor integer upscaler for 24-bit pixel rows with a line buffer.
//
// Input channel (in_valid/in_stall): opcode 0 carries a source pixel, which is
// written to the line buffer and sent out scale_factor times; at the end of a
// source row zero pad bytes follow so the output row is a multiple of four
// bytes. Opcode 1 is a replay tick: it reads one buffered pixel and sends it out
// the same way, for scale_factor-1 further rows. A pixel that arrives while a
// replay is pending gives a single reject transaction; a tick with no replay
// pending is dropped.
// Output channel (out_valid/out_stall): one result transaction per cycle, while
// out_stall is low, from a registered output stage. The first result of an item
// passes stage 1 (line buffer read), stage 2 (emitter) and the output register.
// A pixel or tick item occupies the emitter for scale_factor results, plus up to
// three pad results at a row end; the next item is accepted while the current
// one is still being emitted, so the output runs without gaps while items arrive.
// A stalled output holds its transaction; the emitter and then the input
// stall behind it. Reset clears column, replay state and all valid flags and
// sets both registers to 1; the line buffer is not cleared.
// Configuration: APB writes at 0 (source_width) and 4 (scale_factor); the user
// must write only while idle, which the block itself does not enforce.
module pixel_replicate_upscaler #(
	parameter int unsigned MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pru_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [pru_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [pru_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	// Input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  pru_pkg::op_t                      opcode,
	input  logic [pru_pkg::COLOR_W-1:0]       in_blue,
	input  logic [pru_pkg::COLOR_W-1:0]       in_green,
	input  logic [pru_pkg::COLOR_W-1:0]       in_red,
	// Output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output pru_pkg::kind_t                    kind,
	output logic [pru_pkg::COLOR_W-1:0]       out_blue,
	output logic [pru_pkg::COLOR_W-1:0]       out_green,
	output logic [pru_pkg::COLOR_W-1:0]       out_red,
	output logic                              row_end,
	output logic                              last_of_run
);
	import pru_pkg::*;

	localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned EW  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned SCW = $clog2(MAX_SCALE + 1);
	localparam int unsigned RLW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

	// Configuration registers
	logic [SRC_WIDTH_W-1:0] source_width_q;
	logic [SCALE_W-1:0]     scale_factor_q;
	logic                   cfg_wr;
	reg_idx_t               cfg_idx;

	// Row control state
	logic [CW-1:0]  column_q;
	logic [RLW-1:0] replays_left_q;
	logic           replaying_q;

	// Line buffer
	logic [PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [PIX_W-1:0] rd_q;

	// Accept-stage decode
	logic           in_accept;
	logic [EW-1:0]  eff_w;
	logic [SCW-1:0] eff_s;
	logic [PAD_W-1:0] pad;
	logic [CW-1:0]  col_fix;
	logic           col_last;
	logic           is_pixel;
	logic           is_reject;
	logic           is_tick;
	logic [PIX_W-1:0] in_pix;

	// Stage 1: accepted job; a tick's pixel comes from the line buffer read
	logic             valid_s1;
	logic             reject_s1;
	logic             from_mem_s1;
	logic             last_s1;
	logic [PIX_W-1:0] pix_s1;

	// Stage 2: job being emitted
	logic             valid_s2;
	logic             reject_s2;
	logic             row_last_s2;
	logic [PIX_W-1:0] pix_s2;
	logic [SCW-1:0]   reps_s2;
	logic [PAD_W-1:0] pads_s2;

	// Emit control
	logic           out_load;
	logic           s2_final;
	logic           s2_free;
	logic           s2_take;
	kind_t          emit_kind;
	logic [PIX_W-1:0] emit_pix;
	logic           emit_row_end;

	// Output register
	logic             out_valid_q;
	kind_t            kind_q;
	logic [PIX_W-1:0] out_pix_q;
	logic             row_end_q;
	logic             last_of_run_q;

	// APB write decode and readback
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (cfg_idx)
			REG_SOURCE_WIDTH: prdata = APB_DATA_W'(source_width_q);
			REG_SCALE_FACTOR: prdata = APB_DATA_W'(scale_factor_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q <= SRC_WIDTH_W'(1);
			scale_factor_q <= SCALE_W'(1);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_SOURCE_WIDTH: source_width_q <= pwdata[SRC_WIDTH_W-1:0];
				REG_SCALE_FACTOR: scale_factor_q <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamped register values and row pad (w*s*3 mod 4 pads to w*s mod 4)
	always_comb begin
		if (source_width_q == '0)
			eff_w = EW'(1);
		else if (source_width_q > MAX_WIDTH)
			eff_w = EW'(MAX_WIDTH);
		else
			eff_w = EW'(source_width_q);

		if (scale_factor_q == '0)
			eff_s = SCW'(1);
		else if (scale_factor_q > MAX_SCALE)
			eff_s = SCW'(MAX_SCALE);
		else
			eff_s = SCW'(scale_factor_q);

		pad = PAD_W'(eff_w * eff_s);
	end

	// Accept stage: column fix-up and item classification
	assign in_pix    = {in_red, in_green, in_blue};
	assign in_accept = in_valid && !in_stall;
	assign col_fix   = (EW'(column_q) >= eff_w) ? '0 : column_q;
	assign col_last  = (EW'(col_fix) + EW'(1)) >= eff_w;
	assign is_pixel  = (opcode == OP_PIXEL) && !replaying_q;
	assign is_reject = (opcode == OP_PIXEL) && replaying_q;
	assign is_tick   = (opcode == OP_TICK) && replaying_q;

	// Column and replay bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q       <= '0;
			replays_left_q <= '0;
			replaying_q    <= 1'b0;
		end else if (in_accept && (is_pixel || is_tick)) begin
			column_q <= col_last ? '0 : col_fix + CW'(1);
			if (col_last) begin
				if (is_pixel) begin
					if (eff_s > SCW'(1)) begin
						replaying_q    <= 1'b1;
						replays_left_q <= RLW'(eff_s - SCW'(1));
					end
				end else begin
					if (replays_left_q > RLW'(1)) begin
						replays_left_q <= replays_left_q - RLW'(1);
					end else begin
						replays_left_q <= '0;
						replaying_q    <= 1'b0;
					end
				end
			end
		end else if (in_accept) begin
			column_q <= col_fix;
		end
	end

	// Line buffer: write on source pixel, read on replay tick
	always_ff @(posedge clk) begin
		if (in_accept && is_pixel)
			line_mem[col_fix] <= in_pix;
		if (in_accept && is_tick)
			rd_q <= line_mem[col_fix];
	end

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept && (is_pixel || is_tick || is_reject)) begin
			valid_s1 <= 1'b1;
		end else if (s2_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			reject_s1   <= is_reject;
			from_mem_s1 <= is_tick;
			last_s1     <= col_last;
			pix_s1      <= in_pix;
		end
	end

	// Handshake between stages
	assign out_load = !out_valid_q || !out_stall;
	assign s2_final = reject_s2
		|| (reps_s2 == SCW'(1) && pads_s2 == '0)
		|| (reps_s2 == '0 && pads_s2 == PAD_W'(1));
	assign s2_free  = !valid_s2 || (out_load && s2_final);
	assign s2_take  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;

	// Stage 2: emit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_take) begin
			valid_s2 <= 1'b1;
		end else if (valid_s2 && out_load && s2_final) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take) begin
			reject_s2   <= reject_s1;
			row_last_s2 <= last_s1 && !reject_s1;
			pix_s2      <= from_mem_s1 ? rd_q : pix_s1;
			reps_s2     <= reject_s1 ? '0 : eff_s;
			pads_s2     <= (last_s1 && !reject_s1) ? pad : '0;
		end else if (valid_s2 && out_load) begin
			if (reps_s2 != '0)
				reps_s2 <= reps_s2 - SCW'(1);
			else if (pads_s2 != '0)
				pads_s2 <= pads_s2 - PAD_W'(1);
		end
	end

	// Next result from the stage 2 job
	always_comb begin
		priority if (reject_s2) begin
			emit_kind    = KIND_REJECT;
			emit_pix     = '0;
			emit_row_end = 1'b0;
		end else if (reps_s2 != '0) begin
			emit_kind    = KIND_PIXEL;
			emit_pix     = pix_s2;
			emit_row_end = row_last_s2 && reps_s2 == SCW'(1) && pads_s2 == '0;
		end else begin
			emit_kind    = KIND_PAD;
			emit_pix     = '0;
			emit_row_end = pads_s2 == PAD_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s2) begin
			kind_q        <= emit_kind;
			out_pix_q     <= emit_pix;
			row_end_q     <= emit_row_end;
			last_of_run_q <= s2_final;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign out_blue    = out_pix_q[COLOR_W-1:0];
	assign out_green   = out_pix_q[2*COLOR_W-1:COLOR_W];
	assign out_red     = out_pix_q[3*COLOR_W-1:2*COLOR_W];
	assign row_end     = row_end_q;
	assign last_of_run = last_of_run_q;

endmodule

### sim/tb_pixel_replicate_upscaler.sv
// Self-checking testbench for the pixel replicate upscaler: directed and random traffic.
module tb_pixel_replicate_upscaler;
	timeunit 1ns;
	timeprecision 1ps;

	import pru_pkg::*;

	localparam int unsigned WIDTH_MAX     = DEF_MAX_WIDTH;
	localparam int unsigned SCALE_MAX     = DEF_MAX_SCALE;
	localparam int unsigned ITEM_TARGET   = 370;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned END_CYCLES    = 20;
	localparam int unsigned HOLD_CYCLES   = 250;
	localparam int unsigned IDLE_LIMIT    = 4000;
	localparam int unsigned PRINT_LIMIT   = 50;

	typedef struct packed {
		op_t              op;
		logic [PIX_W-1:0] pix;
	} source_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
		logic               row_end;
		logic               last_of_run;
	} upscaled_t;

	// Clock, reset and DUT ports
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	op_t                   opcode = OP_PIXEL;
	logic [COLOR_W-1:0]    in_blue = '0;
	logic [COLOR_W-1:0]    in_green = '0;
	logic [COLOR_W-1:0]    in_red = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	kind_t                 kind;
	logic [COLOR_W-1:0]    out_blue;
	logic [COLOR_W-1:0]    out_green;
	logic [COLOR_W-1:0]    out_red;
	logic                  row_end;
	logic                  last_of_run;

	// Predictor state: line buffer, row position, replay bookkeeping, registers
	logic [PIX_W-1:0] row_buffer [WIDTH_MAX];
	int unsigned      row_col = 0;
	int unsigned      rows_to_replay = 0;
	bit               replay_on = 1'b0;
	int unsigned      cfg_width = 1;
	int unsigned      cfg_scale = 1;

	upscaled_t    upscaled_q[$];
	source_item_t source_q[$];

	// Run statistics and traffic shaping
	int unsigned items_issued = 0;
	int unsigned pixels_in = 0;
	int unsigned rejects = 0;
	int unsigned ticks_used = 0;
	int unsigned ticks_dropped = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches = 0;
	int unsigned geometries = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	int unsigned idle_cycles = 0;
	bit          sender_calm = 1'b0;
	bit          receiver_calm = 1'b0;
	bit          hold_request = 1'b0;
	source_item_t next_item;

	pixel_replicate_upscaler i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.in_blue     (in_blue),
		.in_green    (in_green),
		.in_red      (in_red),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.out_blue    (out_blue),
		.out_green   (out_green),
		.out_red     (out_red),
		.row_end     (row_end),
		.last_of_run (last_of_run)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT) $display("MISMATCH: %s", msg);
	endtask

	// Registers are clamped when used
	function automatic int unsigned eff_width();
		if (cfg_width < 1) return 1;
		if (cfg_width > WIDTH_MAX) return WIDTH_MAX;
		return cfg_width;
	endfunction

	function automatic int unsigned eff_scale();
		if (cfg_scale < 1) return 1;
		if (cfg_scale > SCALE_MAX) return SCALE_MAX;
		return cfg_scale;
	endfunction

	// One source pixel sent scale times, plus zero pad bytes at the row end
	task automatic replicate_pixel(input logic [PIX_W-1:0] pix, output bit row_done);
		int unsigned w;
		int unsigned s;
		int unsigned pad;
		int unsigned i;
		bit last;
		upscaled_t res;
		w = eff_width();
		s = eff_scale();
		pad = (4 - ((w * s * 3) % 4)) % 4;
		last = (row_col + 1 >= w);
		for (i = 0; i < s; i++) begin
			res = '{KIND_PIXEL, pix[7:0], pix[15:8], pix[23:16],
				last && pad == 0 && i + 1 == s, 1'b0};
			upscaled_q.push_back(res);
		end
		if (last) begin
			for (i = 0; i < pad; i++) begin
				res = '{KIND_PAD, 8'h00, 8'h00, 8'h00, i + 1 == pad, 1'b0};
				upscaled_q.push_back(res);
			end
			row_col = 0;
		end else begin
			row_col++;
		end
		row_done = last;
	endtask

	// Expected results of one accepted transaction
	task automatic expand_source_item(input op_t op, input logic [PIX_W-1:0] pix);
		bit done;
		if (row_col >= eff_width()) row_col = 0;
		if (op == OP_PIXEL) begin
			pixels_in++;
			if (replay_on) begin
				rejects++;
				upscaled_q.push_back('{KIND_REJECT, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1});
				return;
			end
			row_buffer[row_col] = pix;
			replicate_pixel(pix, done);
			if (done && eff_scale() > 1) begin
				replay_on = 1'b1;
				rows_to_replay = eff_scale() - 1;
			end
		end else begin
			if (!replay_on) begin
				ticks_dropped++;
				return;
			end
			ticks_used++;
			replicate_pixel(row_buffer[row_col], done);
			if (done) begin
				if (rows_to_replay > 0) rows_to_replay--;
				if (rows_to_replay == 0) replay_on = 1'b0;
			end
		end
		upscaled_q[upscaled_q.size() - 1].last_of_run = 1'b1;
	endtask

	function automatic int unsigned draw_gap();
		int unsigned r;
		if (sender_calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Input driver: payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_PIXEL;
			in_blue <= '0;
			in_green <= '0;
			in_red <= '0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expand_source_item(opcode, {in_red, in_green, in_blue});
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (source_q.size() > 0) begin
					next_item = source_q.pop_front();
					opcode <= next_item.op;
					in_blue <= next_item.pix[7:0];
					in_green <= next_item.pix[15:8];
					in_red <= next_item.pix[23:16];
					in_valid <= 1'b1;
					gap_left = draw_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got)
			report_mismatch($sformatf("result %0d: %s expected 0x%0h, got 0x%0h",
				results_checked, name, want, got));
	endtask

	task automatic check_result();
		upscaled_t want;
		results_checked++;
		if (upscaled_q.size() == 0) begin
			report_mismatch($sformatf("result %0d: kind %0d arrived with nothing expected",
				results_checked, kind));
			return;
		end
		want = upscaled_q.pop_front();
		check_field("kind", want.kind, kind);
		check_field("out_blue", want.blue, out_blue);
		check_field("out_green", want.green, out_green);
		check_field("out_red", want.red, out_red);
		check_field("row_end", want.row_end, row_end);
		check_field("last_of_run", want.last_of_run, last_of_run);
	endtask

	// Output monitor and receiver stalls, including the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) check_result();
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (receiver_calm) begin
				out_stall <= 1'b0;
			end else begin
				case ($urandom_range(0, 99)) inside
					[0:77]: out_stall <= 1'b0;
					[78:95]: begin
						stall_left = $urandom_range(0, 2);
						out_stall <= 1'b1;
					end
					default: begin
						stall_left = $urandom_range(10, 50);
						out_stall <= 1'b1;
					end
				endcase
			end
		end
	end

	// Watchdog: cycles with no transaction on any port
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("pixel_replicate_upscaler regression: fail");
				$finish;
			end
		end
	end

	// APB access: setup cycle, then access cycle until pready
	task automatic apb_access(input reg_idx_t idx, input bit wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic readback(input reg_idx_t idx, input logic [31:0] want);
		logic [31:0] rd;
		apb_access(idx, 1'b0, '0, rd);
		if (rd !== want)
			report_mismatch($sformatf("register %s read 0x%0h, expected 0x%0h",
				idx.name(), rd, want));
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return r[PIX_W-1:0];
		endcase
	endfunction

	task automatic push_item(input op_t op, input logic [PIX_W-1:0] pix, input bit counted);
		source_q.push_back('{op, pix});
		if (counted) items_issued++;
	endtask

	// Sender pause until the block has nothing left in flight
	task automatic wait_drained();
		while (source_q.size() != 0 || in_valid || upscaled_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Finish any pending replay so the next geometry never reads stale columns
	task automatic settle_block();
		int unsigned w;
		int unsigned n;
		wait_drained();
		if (replay_on) begin
			w = eff_width();
			n = (rows_to_replay - 1) * w + (w - row_col);
			repeat (n) push_item(OP_TICK, rand_pixel(), 1'b1);
			wait_drained();
		end
	endtask

	task automatic set_geometry(input logic [31:0] w, input logic [31:0] s);
		logic [31:0] rd;
		settle_block();
		apb_access(REG_SOURCE_WIDTH, 1'b1, w, rd);
		cfg_width = w[SRC_WIDTH_W-1:0];
		apb_access(REG_SCALE_FACTOR, 1'b1, s, rd);
		cfg_scale = s[SCALE_W-1:0];
		readback(REG_SOURCE_WIDTH, w);
		readback(REG_SCALE_FACTOR, s);
		geometries++;
	endtask

	// Rows at the current geometry; a broken tail cuts a row or its replay short
	task automatic run_rows(input int unsigned rows, input bit partial, input bit break_tail);
		int unsigned w;
		int unsigned s;
		int unsigned start;
		int unsigned n;
		int unsigned total;
		int unsigned r;
		int unsigned t;
		w = eff_width();
		s = eff_scale();
		start = (row_col < w) ? row_col : 0;
		if (partial) begin
			n = $urandom_range(1, 4);
			if (start + n >= w) n = w - start - 1;
			repeat (n) push_item(OP_PIXEL, rand_pixel(), 1'b1);
			return;
		end
		for (r = 0; r < rows; r++) begin
			// ticks with no replay pending are dropped by the block
			if ($urandom_range(0, 9) == 0) push_item(OP_TICK, rand_pixel(), 1'b0);
			n = w - start;
			if (break_tail && r + 1 == rows && n > 1 && $urandom_range(0, 1)) begin
				repeat ($urandom_range(1, n - 1)) push_item(OP_PIXEL, rand_pixel(), 1'b1);
				return;
			end
			repeat (n) push_item(OP_PIXEL, rand_pixel(), 1'b1);
			start = 0;
			total = (s - 1) * w;
			if (break_tail && r + 1 == rows && total > 1)
				total = $urandom_range(1, total - 1);
			for (t = 0; t < total; t++) begin
				if ($urandom_range(0, 99) < 8) push_item(OP_PIXEL, rand_pixel(), 1'b1);
				push_item(OP_TICK, rand_pixel(), 1'b1);
			end
		end
	endtask

	// Stimulus sequence
	initial begin
		int unsigned phase_no;
		int unsigned sel;
		int unsigned rows;
		logic [31:0] w;
		logic [31:0] s;
		bit partial;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset geometry: scale one never replays, a lone tick is dropped
		readback(REG_SOURCE_WIDTH, 32'd1);
		readback(REG_SCALE_FACTOR, 32'd1);
		push_item(OP_PIXEL, 24'h000000, 1'b1);
		push_item(OP_PIXEL, 24'hFFFFFF, 1'b1);
		push_item(OP_PIXEL, 24'h55AA55, 1'b1);
		push_item(OP_TICK, 24'h000000, 1'b0);
		push_item(OP_PIXEL, 24'hAA55AA, 1'b1);

		// Short row with one replay, a pixel rejected during it, a tick after it
		set_geometry(32'd3, 32'd2);
		repeat (3) push_item(OP_PIXEL, rand_pixel(), 1'b1);
		push_item(OP_PIXEL, rand_pixel(), 1'b1);
		repeat (3) push_item(OP_TICK, rand_pixel(), 1'b1);
		push_item(OP_TICK, rand_pixel(), 1'b0);

		// Largest legal geometry, partial row
		set_geometry(32'd4096, 32'd32);
		repeat (2) push_item(OP_PIXEL, rand_pixel(), 1'b1);

		// Zero registers clamp to one; the stale column restarts
		set_geometry(32'd0, 32'd0);
		push_item(OP_PIXEL, rand_pixel(), 1'b1);

		// Oversized registers clamp to the maximum
		set_geometry(32'd8191, 32'd63);
		push_item(OP_PIXEL, rand_pixel(), 1'b1);

		// Narrowing mid-row continues it; clamped scale gives the longest replay
		set_geometry(32'd2, 32'd33);
		push_item(OP_PIXEL, rand_pixel(), 1'b1);

		// Random geometries; the first one carries the long receiver hold-off
		phase_no = 0;
		while (items_issued < ITEM_TARGET) begin
			partial = 1'b0;
			rows = $urandom_range(1, 3);
			sel = $urandom_range(0, 9);
			if (phase_no == 0) begin
				w = 5;
				s = 3;
				rows = 3;
			end else if (sel <= 5) begin
				w = $urandom_range(1, 8);
				s = $urandom_range(1, 6);
			end else if (sel == 6) begin
				w = $urandom_range(1, 3);
				s = $urandom_range(7, 32);
			end else if (sel == 7) begin
				w = $urandom_range(9, 40);
				s = $urandom_range(1, 3);
			end else if (sel == 8) begin
				w = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(4097, 8191));
				s = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(33, 63));
				partial = (w != 0);
			end else begin
				w = 4096;
				s = $urandom_range(0, 1) ? 32'd1 : 32'd32;
				partial = 1'b1;
			end
			set_geometry(w, s);
			if (eff_width() * eff_scale() > 40) rows = 1;
			sender_calm = (phase_no == 0) || ($urandom_range(0, 3) == 0);
			receiver_calm = (phase_no != 0) && ($urandom_range(0, 3) == 0);
			if (phase_no == 0) hold_request = 1'b1;
			run_rows(rows, partial, phase_no != 0 && $urandom_range(0, 3) == 0);
			phase_no++;
		end

		wait_drained();
		repeat (END_CYCLES) @(negedge clk);
		if (upscaled_q.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived", upscaled_q.size()));

		$display("covered %0d pixels (%0d rejected), %0d replay ticks, %0d dropped ticks",
			pixels_in, rejects, ticks_used, ticks_dropped);
		$display("checked %0d results over %0d register settings, %0d mismatches",
			results_checked, geometries, mismatches);
		if (mismatches == 0)
			$display("pixel_replicate_upscaler regression: pass");
		else
			$display("pixel_replicate_upscaler regression: fail");
		$finish;
	end

endmodule

### files.f
hdl/pru_pkg.sv
hdl/pixel_replicate_upscaler.sv
sim/tb_pixel_replicate_upscaler.sv
